// ===== hdl/hrlp_pkg.sv =====
// Package with the types and constants of the request-line parser.
`timescale 1ns / 1ps

package hrlp_pkg;

  localparam int unsigned CountWidth = 10;
  localparam int unsigned ProtoLen   = 8;

  localparam logic [7:0] SpaceChar = 8'h20;
  localparam logic [7:0] NulChar   = 8'h00;

  // Expected protocol token, first character at index 0.
  localparam logic [7:0] ProtoText [ProtoLen] = '{
    8'h48, 8'h54, 8'h54, 8'h50, 8'h2f, 8'h31, 8'h2e, 8'h31
  };

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_PROTO       = 3'd1,
    ST_METHOD_LONG = 3'd2,
    ST_TARGET_LONG = 3'd3,
    ST_LINE_LONG   = 3'd4
  } status_e;

  typedef enum logic [6:0] {
    PH_SKIP_M = 7'b0000001,
    PH_METHOD = 7'b0000010,
    PH_SKIP_T = 7'b0000100,
    PH_TARGET = 7'b0001000,
    PH_SKIP_P = 7'b0010000,
    PH_PROTO  = 7'b0100000,
    PH_AFTER  = 7'b1000000
  } phase_e;

  typedef enum logic {
    FLD_METHOD = 1'b0,
    FLD_TARGET = 1'b1
  } field_e;

  typedef enum logic {
    CFG_METHOD_MAX = 1'b0,
    CFG_TARGET_MAX = 1'b1
  } cfg_index_e;

  typedef struct packed {
    logic       is_status;
    logic [7:0] token_char;
    logic       token_field;
    status_e    line_status;
    logic       last_of_run;
  } result_t;

  // Error recorded when the parse ends in the given phase.
  function automatic status_e end_error(phase_e phase, logic proto_bad);
    status_e err;
    err = ST_OK;
    unique case (phase)
      PH_SKIP_M, PH_METHOD, PH_SKIP_T, PH_TARGET, PH_SKIP_P: err = ST_PROTO;
      PH_PROTO: err = proto_bad ? ST_PROTO : ST_OK;
      PH_AFTER: err = ST_OK;
      default:  err = ST_OK;
    endcase
    return err;
  endfunction

endpackage

// ===== hdl/http_request_line_parser.sv =====
// Top level of the request-line parser: byte state machine and result queue.
`timescale 1ns / 1ps

// Request-line parser. Bytes of one request line (CRLF removed) enter on the
// input channel, one per transaction, with byte_present and line_end flags.
// Each method or target byte gives a character result tagged with its field;
// the item that ends the line also gives one status result. Results leave on
// the output channel one per transaction, last_of_run marking the final one
// of an input item. The configuration channel sets method_max (index 0) and
// target_max (index 1) and is always ready; write it only while idle.
// Each result is queued when its input is accepted and offered from the head.
// Throughput: one input item per cycle while the output is not stalled and
// each item gives at most one result; two results leave as two transactions.
// The parse state is updated on acceptance, and a four-entry result queue
// sits in front of the output. The input is stalled while fewer than two
// queue entries are free, so during an output stall the input keeps taking
// items, including those that give no result, until at least three results wait.
// Reset clears the line state, empties the queue and sets method_max to 15
// and target_max to 1023.
module http_request_line_parser #(
  parameter int unsigned LINE_BUFFER = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_index_i,
  input  logic [9:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] line_byte_i,
  input  logic       byte_present_i,
  input  logic       line_end_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       is_status_o,
  output logic [7:0] token_char_o,
  output logic       token_field_o,
  output logic [2:0] line_status_o,
  output logic       last_of_run_o
);
  import hrlp_pkg::*;

  localparam int unsigned LcWidth   = $clog2(LINE_BUFFER + 1);
  localparam int unsigned QDepth    = 4;
  localparam int unsigned QPtrWidth = $clog2(QDepth);
  localparam int unsigned QCntWidth = $clog2(QDepth + 1);

  logic [CountWidth-1:0] method_max_q, target_max_q;

  phase_e                phase_q, phase_d;
  logic [CountWidth-1:0] token_count_q, token_count_d;
  logic [3:0]            proto_index_q, proto_index_d;
  logic                  proto_mismatch_q, proto_mismatch_d;
  logic                  pending_oversize_q, pending_oversize_d;
  status_e               first_error_q, first_error_d;
  logic [LcWidth-1:0]    line_count_q, line_count_d;
  logic                  line_terminated_q, line_terminated_d;

  logic    in_fire, out_fire;
  logic    emit;
  field_e  emit_field;
  status_e line_code;
  logic    proto_bad_q, proto_bad_d;
  logic    [1:0] push_count;
  result_t char_res, status_res, res0, res1;

  result_t               queue_q [QDepth];
  logic [QPtrWidth-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCntWidth-1:0]  q_count_q;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_count_q > QCntWidth'(QDepth - 2);
  assign out_valid_o = q_count_q != '0;
  assign in_fire     = in_valid_i & ~in_stall_o;
  assign out_fire    = out_valid_o & ~out_stall_i;

  assign proto_bad_q = (proto_index_q != 4'(ProtoLen)) || proto_mismatch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      method_max_q <= CountWidth'(15);
      target_max_q <= CountWidth'(1023);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_METHOD_MAX: method_max_q <= cfg_data_i;
        CFG_TARGET_MAX: target_max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Per-byte parse; the status code is taken before the line state clears.
  always_comb begin
    phase_d            = phase_q;
    token_count_d      = token_count_q;
    proto_index_d      = proto_index_q;
    proto_mismatch_d   = proto_mismatch_q;
    pending_oversize_d = pending_oversize_q;
    first_error_d      = first_error_q;
    line_count_d       = line_count_q;
    line_terminated_d  = line_terminated_q;
    emit               = 1'b0;
    emit_field         = FLD_METHOD;
    line_code          = ST_OK;
    proto_bad_d        = proto_bad_q;

    if (in_fire && byte_present_i) begin
      if (line_count_q < LcWidth'(LINE_BUFFER)) begin
        line_count_d = line_count_q + LcWidth'(1);
      end
      if (!line_terminated_q && first_error_q == ST_OK) begin
        if (line_byte_i == NulChar) begin
          first_error_d     = end_error(phase_q, proto_bad_q);
          line_terminated_d = 1'b1;
        end else if (line_byte_i == SpaceChar) begin
          unique case (phase_q)
            PH_METHOD: begin
              if (pending_oversize_q) first_error_d = ST_METHOD_LONG;
              else phase_d = PH_SKIP_T;
            end
            PH_TARGET: begin
              if (pending_oversize_q) first_error_d = ST_TARGET_LONG;
              else phase_d = PH_SKIP_P;
            end
            PH_PROTO: begin
              if (proto_bad_q) first_error_d = ST_PROTO;
              else phase_d = PH_AFTER;
            end
            PH_SKIP_M, PH_SKIP_T, PH_SKIP_P, PH_AFTER: ;
            default: ;
          endcase
        end else begin
          unique case (phase_q)
            PH_SKIP_M, PH_SKIP_T: begin
              // A zero limit makes the first character already oversized.
              if (((phase_q == PH_SKIP_M) ? method_max_q : target_max_q) == '0) begin
                token_count_d      = '0;
                pending_oversize_d = 1'b1;
              end else begin
                token_count_d      = CountWidth'(1);
                pending_oversize_d = 1'b0;
              end
              phase_d    = (phase_q == PH_SKIP_M) ? PH_METHOD : PH_TARGET;
              emit       = 1'b1;
              emit_field = (phase_q == PH_SKIP_M) ? FLD_METHOD : FLD_TARGET;
            end
            PH_METHOD, PH_TARGET: begin
              if (token_count_q >= ((phase_q == PH_METHOD) ? method_max_q : target_max_q)) begin
                pending_oversize_d = 1'b1;
              end else begin
                token_count_d = token_count_q + CountWidth'(1);
              end
              emit       = 1'b1;
              emit_field = (phase_q == PH_METHOD) ? FLD_METHOD : FLD_TARGET;
            end
            PH_SKIP_P: begin
              phase_d          = PH_PROTO;
              proto_index_d    = 4'd1;
              proto_mismatch_d = line_byte_i != ProtoText[0];
            end
            PH_PROTO: begin
              if (proto_index_q < 4'(ProtoLen)) begin
                if (line_byte_i != ProtoText[proto_index_q[2:0]]) begin
                  proto_mismatch_d = 1'b1;
                end
                proto_index_d = proto_index_q + 4'd1;
              end else if (proto_index_q == 4'(ProtoLen)) begin
                proto_index_d = proto_index_q + 4'd1;
              end
            end
            PH_AFTER: first_error_d = ST_PROTO;
            default: ;
          endcase
        end
      end
    end

    if (in_fire && line_end_i) begin
      proto_bad_d = (proto_index_d != 4'(ProtoLen)) || proto_mismatch_d;
      if (!line_terminated_d && first_error_d == ST_OK) begin
        first_error_d = end_error(phase_d, proto_bad_d);
      end
      line_code = (line_count_d >= LcWidth'(LINE_BUFFER)) ? ST_LINE_LONG : first_error_d;
      phase_d            = PH_SKIP_M;
      token_count_d      = '0;
      proto_index_d      = '0;
      proto_mismatch_d   = 1'b0;
      pending_oversize_d = 1'b0;
      first_error_d      = ST_OK;
      line_count_d       = '0;
      line_terminated_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q            <= PH_SKIP_M;
      token_count_q      <= '0;
      proto_index_q      <= '0;
      proto_mismatch_q   <= 1'b0;
      pending_oversize_q <= 1'b0;
      first_error_q      <= ST_OK;
      line_count_q       <= '0;
      line_terminated_q  <= 1'b0;
    end else begin
      phase_q            <= phase_d;
      token_count_q      <= token_count_d;
      proto_index_q      <= proto_index_d;
      proto_mismatch_q   <= proto_mismatch_d;
      pending_oversize_q <= pending_oversize_d;
      first_error_q      <= first_error_d;
      line_count_q       <= line_count_d;
      line_terminated_q  <= line_terminated_d;
    end
  end

  always_comb begin
    char_res.is_status   = 1'b0;
    char_res.token_char  = line_byte_i;
    char_res.token_field = emit_field;
    char_res.line_status = ST_OK;
    char_res.last_of_run = ~line_end_i;

    status_res.is_status   = 1'b1;
    status_res.token_char  = '0;
    status_res.token_field = FLD_METHOD;
    status_res.line_status = line_code;
    status_res.last_of_run = 1'b1;

    res0       = emit ? char_res : status_res;
    res1       = status_res;
    push_count = {1'b0, emit} + {1'b0, in_fire & line_end_i};
  end

  // Result queue payload; only the head entry is read.
  always_ff @(posedge clk_i) begin
    if (push_count != 2'd0) begin
      queue_q[wr_ptr_q] <= res0;
    end
    if (push_count == 2'd2) begin
      queue_q[wr_ptr_q + QPtrWidth'(1)] <= res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q  <= '0;
      rd_ptr_q  <= '0;
      q_count_q <= '0;
    end else begin
      wr_ptr_q  <= wr_ptr_q + QPtrWidth'(push_count);
      rd_ptr_q  <= rd_ptr_q + QPtrWidth'(out_fire);
      q_count_q <= q_count_q + QCntWidth'(push_count) - QCntWidth'(out_fire);
    end
  end

  assign is_status_o   = queue_q[rd_ptr_q].is_status;
  assign token_char_o  = queue_q[rd_ptr_q].token_char;
  assign token_field_o = queue_q[rd_ptr_q].token_field;
  assign line_status_o = queue_q[rd_ptr_q].line_status;
  assign last_of_run_o = queue_q[rd_ptr_q].last_of_run;

endmodule

// ===== tb/sv/http_request_line_parser_test.sv =====
// Self-checking testbench for the HTTP request-line parser.
`timescale 1ns / 1ps

module http_request_line_parser_test;
  import hrlp_pkg::*;

  localparam int unsigned LineBuffer     = 1024;
  localparam int unsigned RandomItems    = 700;
  localparam int unsigned RandomPhases   = 8;
  localparam int unsigned LongHoldCycles = 300;
  localparam int unsigned DrainCycles    = 8;
  localparam int unsigned CycleLimit     = 1_000_000;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic       cfg_index_i;
  logic [9:0] cfg_data_i;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] line_byte_i;
  logic       byte_present_i;
  logic       line_end_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic       is_status_o;
  logic [7:0] token_char_o;
  logic       token_field_o;
  logic [2:0] line_status_o;
  logic       last_of_run_o;

  http_request_line_parser #(
    .LINE_BUFFER(LineBuffer)
  ) u_dut (.*);

  // Parser state as this testbench sees it.
  phase_e      parse_phase;
  logic [9:0]  token_len;
  logic [3:0]  proto_pos;
  logic        proto_diff;
  logic        size_pending;
  status_e     line_error;
  int unsigned line_bytes;
  logic        parse_ended;
  logic [9:0]  method_limit;
  logic [9:0]  target_limit;
  result_t     awaited_results[$];

  bit          idle_enable = 1'b1;
  bit          hold_output = 1'b0;
  int unsigned items_sent = 0;
  int unsigned lines_sent = 0;
  int unsigned settings_used = 0;
  int unsigned results_seen = 0;
  int unsigned status_count = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("[http_request_line_parser] ERROR");
    $finish;
  end

  function automatic void reset_line_state();
    parse_phase  = PH_SKIP_M;
    token_len    = '0;
    proto_pos    = '0;
    proto_diff   = 1'b0;
    size_pending = 1'b0;
    line_error   = ST_OK;
    line_bytes   = 0;
    parse_ended  = 1'b0;
  endfunction

  function automatic void record_error(status_e code);
    if (line_error == ST_OK) line_error = code;
  endfunction

  function automatic logic proto_wrong();
    return proto_pos != ProtoLen || proto_diff;
  endfunction

  function automatic void end_parse();
    case (parse_phase)
      PH_PROTO: if (proto_wrong()) record_error(ST_PROTO);
      PH_AFTER: ;
      default:  record_error(ST_PROTO);
    endcase
    parse_ended = 1'b1;
  endfunction

  // The position counter stops one past the expected length so that longer tokens fail.
  function automatic void match_proto(logic [7:0] b);
    if (proto_pos < ProtoLen) begin
      if (b != ProtoText[proto_pos]) proto_diff = 1'b1;
      proto_pos++;
    end else if (proto_pos == ProtoLen) begin
      proto_pos++;
    end
  endfunction

  function automatic void open_token(logic [9:0] limit);
    size_pending = (limit == 0);
    token_len    = (limit == 0) ? 10'd0 : 10'd1;
  endfunction

  function automatic void grow_token(logic [9:0] limit);
    if (token_len >= limit) size_pending = 1'b1;
    else token_len++;
  endfunction

  function automatic void parse_line_byte(logic [7:0] b, logic present, logic ends);
    result_t r;
    logic    emit;
    field_e  fld;
    emit = 1'b0;
    fld  = FLD_METHOD;
    if (present) begin
      if (line_bytes < LineBuffer) line_bytes++;
      if (!parse_ended && line_error == ST_OK) begin
        if (b == NulChar) begin
          end_parse();
        end else if (b == SpaceChar) begin
          case (parse_phase)
            PH_METHOD: begin
              if (size_pending) record_error(ST_METHOD_LONG);
              else parse_phase = PH_SKIP_T;
            end
            PH_TARGET: begin
              if (size_pending) record_error(ST_TARGET_LONG);
              else parse_phase = PH_SKIP_P;
            end
            PH_PROTO: begin
              if (proto_wrong()) record_error(ST_PROTO);
              else parse_phase = PH_AFTER;
            end
            default: ;
          endcase
        end else begin
          case (parse_phase)
            PH_SKIP_M: begin
              open_token(method_limit);
              parse_phase = PH_METHOD;
              emit = 1'b1;
            end
            PH_METHOD: begin
              grow_token(method_limit);
              emit = 1'b1;
            end
            PH_SKIP_T: begin
              open_token(target_limit);
              parse_phase = PH_TARGET;
              emit = 1'b1;
              fld  = FLD_TARGET;
            end
            PH_TARGET: begin
              grow_token(target_limit);
              emit = 1'b1;
              fld  = FLD_TARGET;
            end
            PH_SKIP_P: begin
              proto_pos   = '0;
              proto_diff  = 1'b0;
              parse_phase = PH_PROTO;
              match_proto(b);
            end
            PH_PROTO: match_proto(b);
            default:  record_error(ST_PROTO);
          endcase
        end
      end
    end
    if (emit) begin
      r = '0;
      r.token_char  = b;
      r.token_field = fld;
      r.line_status = ST_OK;
      r.last_of_run = !ends;
      awaited_results.push_back(r);
    end
    if (ends) begin
      if (!parse_ended && line_error == ST_OK) end_parse();
      r = '0;
      r.is_status   = 1'b1;
      r.line_status = (line_bytes > LineBuffer - 1) ? ST_LINE_LONG : line_error;
      r.last_of_run = 1'b1;
      awaited_results.push_back(r);
      reset_line_state();
    end
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  // Outputs are stable from the falling edge on, so a transaction seen here
  // completes at the next rising edge.
  always @(negedge clk_i) begin : result_checker
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0b char %0h code %0d",
                 $time, is_status_o, token_char_o, line_status_o);
        error_count++;
      end else begin
        want = awaited_results.pop_front();
        check_field("is_status", want.is_status, is_status_o);
        check_field("token_char", want.token_char, token_char_o);
        check_field("token_field", want.token_field, token_field_o);
        check_field("line_status", want.line_status, line_status_o);
        check_field("last_of_run", want.last_of_run, last_of_run_o);
        if (want.is_status) status_count++;
      end
    end
  end

  initial begin : output_receiver
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_output) begin
        out_stall_i <= 1'b1;
        repeat (LongHoldCycles) @(posedge clk_i);
        hold_output = 1'b0;
        out_stall_i <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Valid stays high between back-to-back transactions and drops only for a gap.
  task automatic send_item(logic [7:0] b, logic present, logic ends);
    logic taken;
    if (idle_enable && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    line_byte_i    <= b;
    byte_present_i <= present;
    line_end_i     <= ends;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    parse_line_byte(b, present, ends);
    if (present || ends) items_sent++;
  endtask

  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_register(cfg_index_e idx, logic [9:0] value);
    logic done;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do begin
      @(negedge clk_i);
      done = cfg_ready_o;
      @(posedge clk_i);
    end while (!done);
  endtask

  task automatic set_limits(logic [9:0] m, logic [9:0] t);
    wait_for_drain();
    write_register(CFG_METHOD_MAX, m);
    write_register(CFG_TARGET_MAX, t);
    cfg_valid_i <= 1'b0;
    method_limit = m;
    target_limit = t;
    settings_used++;
  endtask

  // Empty markers without an end are sprinkled in; they must produce nothing.
  task automatic send_text(logic [7:0] text[$], bit end_marker);
    for (int i = 0; i < text.size(); i++) begin
      if ($urandom_range(0, 15) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(text[i], 1'b1, !end_marker && i == text.size() - 1);
    end
    if (end_marker || text.size() == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    lines_sent++;
  endtask

  function automatic logic [7:0] token_byte();
    logic [7:0] c;
    c = 8'($urandom_range(1, 255));
    return (c == SpaceChar) ? 8'h7e : c;
  endfunction

  function automatic void add_spaces(ref logic [7:0] text[$], input int unsigned count);
    repeat (count) text.push_back(SpaceChar);
  endfunction

  function automatic void add_token(ref logic [7:0] text[$], input logic [9:0] limit);
    int unsigned cap;
    cap = (limit + 2 > 24) ? 24 : limit + 2;
    repeat ($urandom_range(1, cap)) text.push_back(token_byte());
  endfunction

  // Mostly well-formed request lines, with a damaged protocol, a trailing
  // token or an embedded zero byte now and then.
  function automatic void build_request(ref logic [7:0] text[$]);
    add_spaces(text, $urandom_range(0, 2));
    add_token(text, method_limit);
    add_spaces(text, $urandom_range(1, 2));
    add_token(text, target_limit);
    add_spaces(text, $urandom_range(1, 2));
    for (int i = 0; i < ProtoLen; i++) text.push_back(ProtoText[i]);
    case ($urandom_range(0, 15))
      0: text[text.size() - 1 - $urandom_range(0, 7)] = 8'($urandom_range(0, 255));
      1: void'(text.pop_back());
      2: text.push_back(ProtoText[$urandom_range(0, 7)]);
      3: repeat (ProtoLen) void'(text.pop_back());
      default: ;
    endcase
    add_spaces(text, $urandom_range(0, 2));
    if ($urandom_range(0, 9) == 0) text.push_back(token_byte());
    if ($urandom_range(0, 11) == 0) text.insert($urandom_range(0, text.size()), NulChar);
  endfunction

  task automatic send_random_line();
    logic [7:0]  text[$];
    int unsigned kind;
    int unsigned cut;
    kind = $urandom_range(0, 9);
    if (kind == 9) begin
      repeat ($urandom_range(0, 20)) begin
        text.push_back($urandom_range(0, 3) == 0 ? SpaceChar : 8'($urandom_range(0, 255)));
      end
    end else begin
      build_request(text);
      if (kind >= 7) begin
        cut = $urandom_range(0, text.size() - 1);
        while (text.size() > cut) void'(text.pop_back());
      end
    end
    send_text(text, $urandom_range(0, 3) == 0);
  endtask

  task automatic test_directed();
    logic [7:0] text[$];
    // A marker with neither byte nor end gives no result at all.
    send_item(8'hff, 1'b0, 1'b0);
    // The line ends before the method starts.
    send_item(8'h00, 1'b0, 1'b1);
    // The line ends inside the method, on the item that carries its first character.
    send_item(8'hff, 1'b1, 1'b1);
    // A zero byte ends the parse; the byte after it is only counted.
    send_item(8'h78, 1'b1, 1'b0);
    send_item(NulChar, 1'b1, 1'b0);
    send_item(8'h79, 1'b1, 1'b1);
    text = '{SpaceChar, 8'h80, SpaceChar, 8'h01, SpaceChar};
    for (int i = 0; i < ProtoLen; i++) text.push_back(ProtoText[i]);
    send_text(text, 1'b1);
  endtask

  task automatic test_backpressure();
    logic [7:0] text[$];
    wait_for_drain();
    idle_enable = 1'b0;
    hold_output = 1'b1;
    repeat (6) begin
      text.delete();
      build_request(text);
      send_text(text, 1'b0);
    end
    wait_for_drain();
    idle_enable = 1'b1;
  endtask

  task automatic test_random();
    int unsigned goal;
    for (int p = 0; p < RandomPhases; p++) begin
      case (p)
        0: ;  // limits from reset
        1: set_limits(10'd0, 10'd0);
        2: set_limits(10'd1, 10'd2);
        3: set_limits(10'd1023, 10'd0);
        4: set_limits(10'd0, 10'd1023);
        5: set_limits(10'($urandom_range(0, 20)), 10'($urandom_range(0, 20)));
        6: set_limits(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 30)));
        default: set_limits(10'd4, 10'd6);
      endcase
      goal = items_sent + RandomItems / RandomPhases;
      while (items_sent < goal) begin
        idle_enable = (p != RandomPhases - 1) && ($urandom_range(0, 3) != 0);
        send_random_line();
      end
    end
  endtask

  // A well-formed line exactly as long as the buffer must report line too long.
  task automatic test_line_too_long();
    logic [7:0] text[$];
    set_limits(10'd1023, 10'd1023);
    text = '{token_byte(), SpaceChar};
    repeat (LineBuffer - 11) text.push_back(token_byte());
    text.push_back(SpaceChar);
    for (int i = 0; i < ProtoLen; i++) text.push_back(ProtoText[i]);
    send_text(text, 1'b1);
  endtask

  initial begin : main
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = 1'b0;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    line_byte_i    = '0;
    byte_present_i = 1'b0;
    line_end_i     = 1'b0;
    method_limit   = 10'd15;
    target_limit   = 10'd1023;
    reset_line_state();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_backpressure();
    test_random();
    test_line_too_long();
    wait_for_drain();

    $display("Sent %0d items in %0d lines across %0d limit settings plus the reset values.",
             items_sent, lines_sent, settings_used);
    $display("Checked %0d results, %0d of them line status, with %0d mismatches.",
             results_seen, status_count, error_count);
    if (error_count == 0) begin
      $display("[http_request_line_parser] OK");
    end else begin
      $display("[http_request_line_parser] ERROR");
    end
    $finish;
  end

endmodule
